// File: rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared widths and constants of the binomial coefficient core.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // Operand and result widths
  localparam int N_W    = 6;
  localparam int COEF_W = 64;

  // Largest supported set size; larger n gives a zero result
  localparam int MAX_N = 63;

  // Running product acc * m before the exact division. The largest value is
  // i * C(n, i), which needs 65 bits at n = 63; keep a whole number of digits.
  localparam int DIG_W  = 2;
  localparam int PROD_W = 72;

  // Divider digit steps and its counter
  localparam int DIV_STEPS = PROD_W / DIG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // Partial remainder joined with one dividend digit
  localparam int REM_W = N_W + DIG_W;

endpackage : bcc_pkg

// File: rtl/bcc_in_if.sv
// ----------------------------------------------------------------------------
// bcc_in_if
// Operand channel: one item carries the pair n, k.
// ----------------------------------------------------------------------------
interface bcc_in_if import bcc_pkg::*; ();

  logic           valid;
  logic           ready;
  logic [N_W-1:0] n;
  logic [N_W-1:0] k;

  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);

endinterface : bcc_in_if

// File: rtl/bcc_out_if.sv
// ----------------------------------------------------------------------------
// bcc_out_if
// Result channel: one item carries the coefficient.
// ----------------------------------------------------------------------------
interface bcc_out_if import bcc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);

endinterface : bcc_out_if

// File: rtl/bcc_divider.sv
// ----------------------------------------------------------------------------
// bcc_divider
// Radix-4 restoring divider: the dividend shifts out two bits per cycle, the
// quotient digits shift in behind it, and only the narrow remainder is kept.
// ----------------------------------------------------------------------------
module bcc_divider import bcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [N_W-1:0]    divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] shreg;
  logic [N_W-1:0]    rem;
  logic [N_W-1:0]    dvs;

  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  mul1;
  logic [REM_W-1:0]  mul2;
  logic [REM_W-1:0]  mul3;
  logic [DIG_W-1:0]  qdig;
  logic [N_W-1:0]    rem_next;

  // Pick the largest multiple of the divisor that fits the trial remainder
  always_comb begin
    trial = {rem, shreg[PROD_W-1 -: DIG_W]};
    mul1  = REM_W'(dvs);
    mul2  = REM_W'({dvs, 1'b0});
    mul3  = mul1 + mul2;
    priority if (trial >= mul3) begin
      qdig     = DIG_W'(3);
      rem_next = N_W'(trial - mul3);
    end else if (trial >= mul2) begin
      qdig     = DIG_W'(2);
      rem_next = N_W'(trial - mul2);
    end else if (trial >= mul1) begin
      qdig     = DIG_W'(1);
      rem_next = N_W'(trial - mul1);
    end else begin
      qdig     = '0;
      rem_next = N_W'(trial);
    end
  end

  // Sequence the digit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Advance the shift register and the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[PROD_W-DIG_W-1:0], qdig};
      rem   <= rem_next;
    end
  end

  assign quotient = shreg;

endmodule : bcc_divider

// File: rtl/binomial_coefficient_core.sv
// ----------------------------------------------------------------------------
// binomial_coefficient_core
// n choose k by the multiplicative scheme with a digit-serial exact divider.
// ----------------------------------------------------------------------------
// Usage:
//   op  (valid/ready): one item carries n and k, accepted when both are high.
//   res (valid/ready): one item per operand item carries the coefficient.
//   k > n gives 0; k = 0 or k = n gives 1; otherwise k is folded to
//   kr = min(k, n-k) and the running value n-kr+1 is multiplied by n-kr+i
//   and divided exactly by i for i = 2 .. kr.
// Timing:
//   One item at a time. Each loop step is the multiply by the 6-bit factor
//   in S_MUL, then the radix-4 divider in S_DIV, which walks the 72-bit
//   product two bits per cycle. The result goes from S_DONE into the
//   output register once the slot is free. op.ready is high only while no
//   item is in progress.
// Reset and stalls:
//   rst clears the sequencer, the divider control and the output valid flag.
//   The output register holds a finished result while the receiver stalls,
//   and a new item is accepted meanwhile; its own result waits for the slot.
// ----------------------------------------------------------------------------
module binomial_coefficient_core import bcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bcc_in_if.sink     op,
  bcc_out_if.source  res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [N_W:0] MAX_N_V = (N_W + 1)'(MAX_N);

  state_t            state;
  logic [N_W-1:0]    nn;
  logic [N_W-1:0]    kk;
  logic [N_W-1:0]    idx;
  logic [PROD_W-1:0] acc;

  // Operand decode
  logic              k_gt_n;
  logic              n_big;
  logic              trivial;
  logic [N_W-1:0]    k_red;
  logic [N_W-1:0]    base;

  // Step datapath
  logic [N_W-1:0]    factor;
  logic [PROD_W-1:0] product;
  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] div_quot;
  logic              slot_free;

  // Classify the pair and fold k to the smaller side
  always_comb begin
    k_gt_n  = op.k > op.n;
    n_big   = {1'b0, op.n} > MAX_N_V;
    trivial = (op.k == '0) || (op.k == op.n);
    k_red   = ({op.k, 1'b0} > {1'b0, op.n}) ? (op.n - op.k) : op.k;
    base    = op.n - k_red + N_W'(1);
  end

  // Multiply by the next factor; the divider registers the product
  assign factor    = nn - kk + idx;
  assign product   = acc * PROD_W'(factor);
  assign div_start = (state == S_MUL);
  assign slot_free = !res.valid || res.ready;
  assign op.ready  = (state == S_IDLE);

  bcc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (idx),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      // Drop a taken item unless a finished one moves into the slot
      if (res.valid && res.ready && (state != S_DONE)) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (op.valid) begin
            nn  <= op.n;
            kk  <= k_red;
            idx <= N_W'(2);
            priority if (k_gt_n || n_big) begin
              acc   <= '0;
              state <= S_DONE;
            end else if (trivial) begin
              acc   <= PROD_W'(1);
              state <= S_DONE;
            end else begin
              acc   <= PROD_W'(base);
              state <= (k_red == N_W'(1)) ? S_DONE : S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            acc <= div_quot;
            if (idx == kk) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + N_W'(1);
              state <= S_MUL;
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            res.valid       <= 1'b1;
            res.coefficient <= acc[COEF_W-1:0];
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : binomial_coefficient_core

// File: rtl/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks of the binomial coefficient core, bound to the top level.
// ----------------------------------------------------------------------------
module bcc_checker import bcc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              op_valid,
  input logic              op_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [COEF_W-1:0] coefficient
);

  // A stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result withdrawn while stalled");

  // One item at a time: acceptance closes the operand channel
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> !op_ready)
    else $error("operand channel open while an item is in progress");

  // No result can be offered right after reset
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result offered straight after reset");

  // A fresh result only follows completed work, never the acceptance edge
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready && !res_valid |=> !res_valid)
    else $error("result appeared in the cycle after acceptance");

  // A stalled result keeps its value
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(coefficient))
    else $error("result changed while stalled");

endmodule : bcc_checker

bind binomial_coefficient_core bcc_checker u_bcc_checker (
  .clk         (clk),
  .rst         (rst),
  .op_valid    (op.valid),
  .op_ready    (op.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .coefficient (res.coefficient)
);
